FILE: rtl/fingertip_to_mouse_converter_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef FINGERTIP_TO_MOUSE_CONVERTER_ASSERT_SVH
`define FINGERTIP_TO_MOUSE_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ftm_pkg.sv
package ftm_pkg;

    localparam int POS_W      = 16;
    localparam int CNT_W      = 4;
    localparam int GAIN_W     = 8;
    localparam int WIN_W      = 4;
    localparam int DIFF_W     = POS_W + 1;
    localparam int ENT_W      = 26;
    localparam int FRAC_SH    = 8;
    localparam int IN_W       = 104;
    localparam int OUT_W      = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOVE_GAIN     = 3'd0,
        REG_SCROLL_GAIN   = 3'd1,
        REG_MOVE_WINDOW   = 3'd2,
        REG_SCROLL_WINDOW = 3'd3,
        REG_HOVER_LIMIT   = 3'd4,
        REG_CLICK_PREPARE = 3'd5,
        REG_CLICK_PRESS   = 3'd6,
        REG_CLICK_RELEASE = 3'd7
    } t_cfg_reg;

    localparam logic [CNT_W-1:0] CNT_NONE = 4'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 4'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 4'd2;
    localparam logic [CNT_W-1:0] CNT_FIVE = 4'd5;

    localparam logic [GAIN_W-1:0]       RST_MOVE_GAIN     = 8'd48;
    localparam logic [GAIN_W-1:0]       RST_SCROLL_GAIN   = 8'd16;
    localparam logic [WIN_W-1:0]        RST_MOVE_WINDOW   = 4'd5;
    localparam logic [WIN_W-1:0]        RST_SCROLL_WINDOW = 4'd3;
    localparam logic signed [POS_W-1:0] RST_HOVER_LIMIT   = 16'sd320;
    localparam logic signed [POS_W-1:0] RST_CLICK_PREPARE = -16'sd640;
    localparam logic signed [POS_W-1:0] RST_CLICK_PRESS   = -16'sd800;
    localparam logic signed [POS_W-1:0] RST_CLICK_RELEASE = -16'sd640;

    localparam logic signed [POS_W-1:0] SCROLL_DEPTH_LIMIT = -16'sd640;

    localparam logic signed [POS_W-1:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [POS_W-1:0] SAT_NEG = 16'sh8000;
    localparam int SAT_POS_MAG = 32767;
    localparam int SAT_NEG_MAG = 32768;

    typedef struct packed {
        logic signed [ENT_W-1:0] dy;
        logic signed [ENT_W-1:0] dx;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_win_ctl;

    typedef struct packed {
        logic                    click;
        logic                    move_valid;
        logic signed [POS_W-1:0] move_dx;
        logic signed [POS_W-1:0] move_dy;
        logic                    wheel_valid;
        logic signed [POS_W-1:0] wheel_vert;
        logic signed [POS_W-1:0] wheel_horiz;
    } t_result;

endpackage

FILE: rtl/fingertip_to_mouse_converter.sv
// Channel   Direction  Data bits (lowest first)
// s_axis    in         finger_count, tip_x, tip_y, tip_z, tip2_x, tip2_y, tip2_z
// m_axis    out        click_pulse, move_valid, move_dx, move_dy, wheel_valid,
//                      wheel_vert, wheel_horiz, sync_pulse
// cfg       in         register index and write data, one write per enabled cycle
//
// In a request that issues a move or wheel step, the window shift runs one memory entry
// per cycle over the effective window length and the shared divider retires two quotient
// bits per cycle. Other requests skip both.
// One request is processed at a time; the next is taken while a result waits.
// Reset is synchronous and clears the window valid bits at once, without a sweep.
module fingertip_to_mouse_converter #(
    parameter int MAX_WINDOW = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // finger_count, tip_x, tip_y, tip_z, tip2_x, tip2_y, tip2_z
    input  logic [ftm_pkg::IN_W-1:0]            s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // click_pulse, move_valid, move_dx, move_dy, wheel_valid, wheel_vert,
    // wheel_horiz, sync_pulse
    output logic [ftm_pkg::OUT_W-1:0]           m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ftm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    `include "fingertip_to_mouse_converter_assert.svh"

    localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WCW = $clog2(MAX_WINDOW + 1);
    localparam int SW  = ftm_pkg::ENT_W + $clog2(MAX_WINDOW);
    localparam int MW  = SW + 1;
    localparam int DW  = MW - ftm_pkg::FRAC_SH;
    localparam int PW  = ftm_pkg::POS_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_EVAL   = 10'b0000000010,
        S_MUL    = 10'b0000000100,
        S_CHECK  = 10'b0000001000,
        S_SHIFT0 = 10'b0000010000,
        S_SHIFT  = 10'b0000100000,
        S_PUSH   = 10'b0001000000,
        S_DIVGO  = 10'b0010000000,
        S_DIV    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    function automatic logic signed [PW-1:0] sat(logic neg, logic [DW-1:0] q);
        logic signed [PW-1:0] res;
        if (neg) begin
            if (q > DW'(ftm_pkg::SAT_NEG_MAG)) res = ftm_pkg::SAT_NEG;
            else res = PW'(-q);
        end else begin
            if (q > DW'(ftm_pkg::SAT_POS_MAG)) res = ftm_pkg::SAT_POS;
            else res = PW'(q);
        end
        return res;
    endfunction

    t_state r_state;
    t_state n_state;

    logic [ftm_pkg::GAIN_W-1:0] r_move_gain;
    logic [ftm_pkg::GAIN_W-1:0] r_scroll_gain;
    logic [ftm_pkg::WIN_W-1:0]  r_move_window;
    logic [ftm_pkg::WIN_W-1:0]  r_scroll_window;
    logic signed [PW-1:0]       r_hover_limit;
    logic signed [PW-1:0]       r_click_prepare;
    logic signed [PW-1:0]       r_click_press;
    logic signed [PW-1:0]       r_click_release;

    logic signed [PW-1:0] r_ref_x;
    logic signed [PW-1:0] r_ref_y;
    logic signed [PW-1:0] r_last_depth;
    logic                 r_ptr_restart;
    logic                 r_scr_restart;
    logic                 r_click_latched;
    logic                 r_out_valid;

    logic [ftm_pkg::CNT_W-1:0] r_cnt_in;
    logic signed [PW-1:0]      r_tx;
    logic signed [PW-1:0]      r_ty;
    logic signed [PW-1:0]      r_tz;
    logic signed [PW-1:0]      r_t2x;
    logic signed [PW-1:0]      r_t2y;
    logic signed [PW-1:0]      r_t2z;

    logic                                 r_mode_scroll;
    logic signed [ftm_pkg::DIFF_W-1:0]    r_dx_diff;
    logic signed [ftm_pkg::DIFF_W-1:0]    r_dy_diff;
    logic signed [ftm_pkg::ENT_W-1:0]     r_cdx;
    logic signed [ftm_pkg::ENT_W-1:0]     r_cdy;
    logic [WCW-1:0]                       r_w;
    logic [AW-1:0]                        r_rd;
    logic signed [SW-1:0]                 r_acc_x;
    logic signed [SW-1:0]                 r_acc_y;
    logic signed [SW-1:0]                 r_sum_x;
    logic signed [SW-1:0]                 r_sum_y;
    logic                                 r_neg_x;
    logic                                 r_neg_y;
    ftm_pkg::t_result                     r_res;
    ftm_pkg::t_result                     r_out;

    logic is_rst;
    logic is_ptr;
    logic is_scr;
    logic signed [ftm_pkg::DIFF_W-1:0] sum_x;
    logic signed [ftm_pkg::DIFF_W-1:0] sum_y;
    logic signed [ftm_pkg::DIFF_W-1:0] sum_z;
    logic signed [PW-1:0] sel_x;
    logic signed [PW-1:0] sel_y;
    logic signed [PW-1:0] sel_z;
    logic signed [PW-1:0] ref_ex;
    logic signed [PW-1:0] ref_ey;
    logic signed [ftm_pkg::DIFF_W-1:0] diff_x;
    logic signed [ftm_pkg::DIFF_W-1:0] diff_y;
    logic hover_hit;
    logic restart;
    logic depth_new;
    logic ptr_dip;
    logic ptr_press;
    logic latch_mid;
    logic latch_rel;
    logic ptr_move;
    logic scr_move;
    logic go_mul;
    logic nz;
    logic out_free;

    logic [ftm_pkg::GAIN_W-1:0]       gain;
    logic signed [ftm_pkg::ENT_W-1:0] gain_s;
    logic signed [ftm_pkg::ENT_W-1:0] dxe;
    logic signed [ftm_pkg::ENT_W-1:0] dye;
    logic signed [ftm_pkg::ENT_W-1:0] prod_x;
    logic signed [ftm_pkg::ENT_W-1:0] prod_y;
    logic [ftm_pkg::WIN_W-1:0]        win_raw;
    logic [WCW-1:0]                   w_eff;
    logic [AW-1:0]                    last_idx;

    logic signed [MW-1:0] sx_ext;
    logic signed [MW-1:0] sy_ext;
    logic [MW-1:0]        mag_x;
    logic [MW-1:0]        mag_y;
    logic [MW-1:0]        round_add;
    logic [MW-1:0]        num_x;
    logic [MW-1:0]        num_y;

    ftm_pkg::t_win_ctl win_ctl;
    logic [AW-1:0]     win_rd_addr;
    logic [AW-1:0]     win_wr_addr;
    ftm_pkg::t_entry   win_wr_data;
    ftm_pkg::t_entry   win_rd_data;

    logic          div_start;
    logic          div_done;
    logic [DW-1:0] quot_x;
    logic [DW-1:0] quot_y;

    always_comb begin
        is_rst = (r_cnt_in == ftm_pkg::CNT_NONE) || (r_cnt_in == ftm_pkg::CNT_FIVE);
        is_ptr = (r_cnt_in == ftm_pkg::CNT_ONE);
        is_scr = (r_cnt_in == ftm_pkg::CNT_TWO);
        sum_x  = ftm_pkg::DIFF_W'(r_tx) + ftm_pkg::DIFF_W'(r_t2x);
        sum_y  = ftm_pkg::DIFF_W'(r_ty) + ftm_pkg::DIFF_W'(r_t2y);
        sum_z  = ftm_pkg::DIFF_W'(r_tz) + ftm_pkg::DIFF_W'(r_t2z);
        sel_x  = is_scr ? sum_x[PW:1] : r_tx;
        sel_y  = is_scr ? sum_y[PW:1] : r_ty;
        sel_z  = is_scr ? sum_z[PW:1] : r_tz;
        hover_hit = sel_z > r_hover_limit;
        restart   = is_scr ? r_scr_restart : r_ptr_restart;
        ref_ex    = restart ? sel_x : r_ref_x;
        ref_ey    = restart ? sel_y : r_ref_y;
        diff_x    = ftm_pkg::DIFF_W'(sel_x) - ftm_pkg::DIFF_W'(ref_ex);
        diff_y    = ftm_pkg::DIFF_W'(ref_ey) - ftm_pkg::DIFF_W'(sel_y);
        depth_new = sel_z != r_last_depth;
        ptr_dip   = (sel_z < r_click_prepare) && depth_new;
        ptr_press = ptr_dip && (sel_z < r_click_press) && !r_click_latched;
        latch_mid = r_click_latched || ptr_press;
        latch_rel = (sel_z > r_click_release) && latch_mid;
        ptr_move  = sel_z > r_click_prepare;
        scr_move  = depth_new && (sel_z < ftm_pkg::SCROLL_DEPTH_LIMIT);
        go_mul    = !hover_hit && ((is_ptr && ptr_move) || (is_scr && scr_move));
        nz        = r_mode_scroll ? (r_cdy != '0) : ((r_cdx != '0) || (r_cdy != '0));
        out_free  = !r_out_valid || m_axis_tready;
    end

    always_comb begin
        gain   = r_mode_scroll ? r_scroll_gain : r_move_gain;
        gain_s = $signed(ftm_pkg::ENT_W'(gain));
        dxe    = ftm_pkg::ENT_W'(r_dx_diff);
        dye    = ftm_pkg::ENT_W'(r_dy_diff);
        prod_x = dxe * gain_s;
        prod_y = dye * gain_s;
    end

    always_comb begin
        win_raw = r_mode_scroll ? r_scroll_window : r_move_window;
        if (win_raw == '0) begin
            w_eff = WCW'(1);
        end else if (int'(win_raw) > MAX_WINDOW) begin
            w_eff = WCW'(MAX_WINDOW);
        end else begin
            w_eff = WCW'(win_raw);
        end
        last_idx = AW'(r_w - WCW'(1));
    end

    always_comb begin
        sx_ext    = MW'(r_sum_x);
        sy_ext    = MW'(r_sum_y);
        mag_x     = r_sum_x[SW-1] ? MW'(-sx_ext) : MW'(sx_ext);
        mag_y     = r_sum_y[SW-1] ? MW'(-sy_ext) : MW'(sy_ext);
        round_add = r_mode_scroll ? (MW'(r_w) << (ftm_pkg::FRAC_SH - 1)) : '0;
        num_x     = mag_x + round_add;
        num_y     = mag_y + round_add;
    end

    always_comb begin
        win_ctl       = '0;
        win_rd_addr   = '0;
        win_wr_addr   = '0;
        win_wr_data   = win_rd_data;
        win_ctl.clear = (r_state == S_EVAL) && !hover_hit && restart && (is_ptr || is_scr);
        case (r_state)
            S_SHIFT0: begin
                win_ctl.rd_en = (r_w != WCW'(1));
                win_rd_addr   = AW'(1);
            end
            S_SHIFT: begin
                win_ctl.rd_en = (r_rd != last_idx);
                win_rd_addr   = r_rd + AW'(1);
                win_ctl.wr_en = 1'b1;
                win_wr_addr   = r_rd - AW'(1);
            end
            S_PUSH: begin
                win_ctl.wr_en  = 1'b1;
                win_wr_addr    = last_idx;
                win_wr_data.dx = r_cdx;
                win_wr_data.dy = r_cdy;
            end
            default: ;
        endcase
    end

    assign div_start = (r_state == S_DIVGO);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_axis_tvalid) n_state = S_EVAL;
            S_EVAL:   n_state = go_mul ? S_MUL : S_DONE;
            S_MUL:    n_state = S_CHECK;
            S_CHECK:  n_state = nz ? S_SHIFT0 : S_DONE;
            S_SHIFT0: n_state = (r_w == WCW'(1)) ? S_PUSH : S_SHIFT;
            S_SHIFT:  if (r_rd == last_idx) n_state = S_PUSH;
            S_PUSH:   n_state = S_DIVGO;
            S_DIVGO:  n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_move_gain     <= ftm_pkg::RST_MOVE_GAIN;
            r_scroll_gain   <= ftm_pkg::RST_SCROLL_GAIN;
            r_move_window   <= ftm_pkg::RST_MOVE_WINDOW;
            r_scroll_window <= ftm_pkg::RST_SCROLL_WINDOW;
            r_hover_limit   <= ftm_pkg::RST_HOVER_LIMIT;
            r_click_prepare <= ftm_pkg::RST_CLICK_PREPARE;
            r_click_press   <= ftm_pkg::RST_CLICK_PRESS;
            r_click_release <= ftm_pkg::RST_CLICK_RELEASE;
            r_ref_x         <= '0;
            r_ref_y         <= '0;
            r_last_depth    <= '0;
            r_ptr_restart   <= 1'b1;
            r_scr_restart   <= 1'b1;
            r_click_latched <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (ftm_pkg::t_cfg_reg'(i_cfg_index))
                    ftm_pkg::REG_MOVE_GAIN:     r_move_gain     <= i_cfg_data[ftm_pkg::GAIN_W-1:0];
                    ftm_pkg::REG_SCROLL_GAIN:   r_scroll_gain   <= i_cfg_data[ftm_pkg::GAIN_W-1:0];
                    ftm_pkg::REG_MOVE_WINDOW:   r_move_window   <= i_cfg_data[ftm_pkg::WIN_W-1:0];
                    ftm_pkg::REG_SCROLL_WINDOW: r_scroll_window <= i_cfg_data[ftm_pkg::WIN_W-1:0];
                    ftm_pkg::REG_HOVER_LIMIT:   r_hover_limit   <= i_cfg_data;
                    ftm_pkg::REG_CLICK_PREPARE: r_click_prepare <= i_cfg_data;
                    ftm_pkg::REG_CLICK_PRESS:   r_click_press   <= i_cfg_data;
                    ftm_pkg::REG_CLICK_RELEASE: r_click_release <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EVAL) begin
                if (is_rst) begin
                    r_ptr_restart <= 1'b1;
                    r_scr_restart <= 1'b1;
                end else if (is_ptr) begin
                    r_scr_restart <= 1'b1;
                    if (hover_hit) begin
                        r_ptr_restart <= 1'b1;
                    end else begin
                        r_ptr_restart <= 1'b0;
                        if (restart || ptr_move) begin
                            r_ref_x <= sel_x;
                            r_ref_y <= sel_y;
                        end
                        if (ptr_dip) begin
                            r_last_depth <= sel_z;
                        end
                        r_click_latched <= latch_mid && !latch_rel;
                    end
                end else if (is_scr) begin
                    r_ptr_restart <= 1'b1;
                    if (hover_hit) begin
                        r_scr_restart <= 1'b1;
                    end else begin
                        r_scr_restart <= 1'b0;
                        if (restart || scr_move) begin
                            r_ref_x <= sel_x;
                            r_ref_y <= sel_y;
                        end
                        if (depth_new) begin
                            r_last_depth <= sel_z;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cnt_in <= s_axis_tdata[3:0];
            r_tx     <= s_axis_tdata[19:4];
            r_ty     <= s_axis_tdata[35:20];
            r_tz     <= s_axis_tdata[51:36];
            r_t2x    <= s_axis_tdata[67:52];
            r_t2y    <= s_axis_tdata[83:68];
            r_t2z    <= s_axis_tdata[99:84];
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out <= r_res;
        end
        case (r_state)
            S_EVAL: begin
                r_res         <= '0;
                r_res.click   <= is_ptr && !hover_hit && ptr_press;
                r_dx_diff     <= diff_x;
                r_dy_diff     <= diff_y;
                r_mode_scroll <= is_scr;
            end
            S_MUL: begin
                r_cdx <= prod_x;
                r_cdy <= prod_y;
            end
            S_CHECK: begin
                r_w <= w_eff;
                if (nz) begin
                    r_res.move_valid  <= !r_mode_scroll;
                    r_res.wheel_valid <= r_mode_scroll;
                end
            end
            S_SHIFT0: begin
                r_acc_x <= '0;
                r_acc_y <= '0;
                r_rd    <= AW'(1);
            end
            S_SHIFT: begin
                r_acc_x <= r_acc_x + SW'(win_rd_data.dx);
                r_acc_y <= r_acc_y + SW'(win_rd_data.dy);
                r_rd    <= r_rd + AW'(1);
            end
            S_PUSH: begin
                r_sum_x <= r_acc_x + SW'(r_cdx);
                r_sum_y <= r_acc_y + SW'(r_cdy);
            end
            S_DIVGO: begin
                r_neg_x <= r_sum_x[SW-1];
                r_neg_y <= r_sum_y[SW-1];
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_mode_scroll) begin
                        r_res.wheel_horiz <= sat(r_neg_x, quot_x);
                        r_res.wheel_vert  <= sat(r_neg_y, quot_y);
                    end else begin
                        r_res.move_dx <= sat(r_neg_x, quot_x);
                        r_res.move_dy <= sat(r_neg_y, quot_y);
                    end
                end
            end
            default: ;
        endcase
    end

    ftm_win_mem #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_win_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_rd_addr (win_rd_addr),
        .i_wr_addr (win_wr_addr),
        .i_wr_data (win_wr_data),
        .o_rd_data (win_rd_data)
    );

    ftm_div #(
        .DW (DW),
        .VW (WCW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_dvd_a  (num_x[MW-1:ftm_pkg::FRAC_SH]),
        .i_dvd_b  (num_y[MW-1:ftm_pkg::FRAC_SH]),
        .i_dvs    (r_w),
        .o_done   (div_done),
        .o_quot_a (quot_x),
        .o_quot_b (quot_y)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000,
                            r_out.click || r_out.move_valid || r_out.wheel_valid,
                            r_out.wheel_horiz, r_out.wheel_vert, r_out.wheel_valid,
                            r_out.move_dy, r_out.move_dx, r_out.move_valid, r_out.click};

    `FTM_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == S_EVAL, "accepted request did not enter evaluation")
    `FTM_ASSERT_IMPLY(a_div_in_state, i_clk, i_rst_n, div_done, r_state == S_DIV, "divider finished outside the divide state")
    `FTM_ASSERT_IMPLY(a_shift_bound, i_clk, i_rst_n, r_state == S_SHIFT, WCW'(r_rd) < r_w, "window read beyond the effective window")
    `FTM_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, (r_state == S_DONE) && out_free, m_axis_tvalid, "finished result not presented")

endmodule

FILE: rtl/ftm_win_mem.sv
module ftm_win_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ftm_pkg::t_win_ctl i_ctl,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  ftm_pkg::t_entry   i_wr_data,
    output ftm_pkg::t_entry   o_rd_data
);

    ftm_pkg::t_entry r_mem [DEPTH];
    ftm_pkg::t_entry r_rd_data;
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry that was never written since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

FILE: rtl/ftm_div.sv
module ftm_div #(
    parameter int DW = 22,
    parameter int VW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dvd_a,
    input  logic [DW-1:0] i_dvd_b,
    input  logic [VW-1:0] i_dvs,
    output logic          o_done,
    output logic [DW-1:0] o_quot_a,
    output logic [DW-1:0] o_quot_b
);

    localparam int DWE   = DW + (DW % 2);
    localparam int STEPS = DWE / 2;
    localparam int SCW   = $clog2(STEPS + 1);

    typedef struct packed {
        logic [VW:0]    rem;
        logic [DWE-1:0] quo;
    } t_lane;

    // Two restoring steps per cycle; quotient bits fill the dividend from the bottom.
    function automatic t_lane radix4(t_lane cur, logic [VW-1:0] dvs);
        t_lane       nx;
        logic [VW:0] trial;
        nx = cur;
        for (int k = 0; k < 2; k++) begin
            trial  = {nx.rem[VW-1:0], nx.quo[DWE-1]};
            nx.quo = {nx.quo[DWE-2:0], 1'b0};
            if (trial >= {1'b0, dvs}) begin
                nx.rem    = trial - {1'b0, dvs};
                nx.quo[0] = 1'b1;
            end else begin
                nx.rem = trial;
            end
        end
        return nx;
    endfunction

    t_lane          r_a;
    t_lane          r_b;
    logic [VW-1:0]  r_dvs;
    logic [SCW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SCW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - SCW'(1);
                if (r_cnt == SCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a.rem <= '0;
            r_a.quo <= DWE'(i_dvd_a);
            r_b.rem <= '0;
            r_b.quo <= DWE'(i_dvd_b);
            r_dvs   <= i_dvs;
        end else if (r_busy) begin
            r_a <= radix4(r_a, r_dvs);
            r_b <= radix4(r_b, r_dvs);
        end
    end

    assign o_done   = r_done;
    assign o_quot_a = r_a.quo[DW-1:0];
    assign o_quot_b = r_b.quo[DW-1:0];

endmodule

FILE: tb/sv/tb_fingertip_to_mouse_converter.sv
`timescale 1ns / 100ps

module tb_fingertip_to_mouse_converter;
    import ftm_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_FRAMES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int send_idle;
    int recv_idle;
    bit hold_req;
    int stall_cycles;
    int cur_x;
    int cur_y;
    int last_z;

    class mouse_event_board;
        int move_gain = 48;
        int scroll_gain = 16;
        int move_win = 5;
        int scroll_win = 3;
        int hover = 320;
        int prep = -640;
        int press = -800;
        int rel_lvl = -640;
        int ref_x;
        int ref_y;
        int last_depth;
        bit ptr_restart = 1'b1;
        bit scr_restart = 1'b1;
        bit latched;
        longint win_dx[8];
        longint win_dy[8];
        t_result pending_events[$];
        bit pending_sync[$];
        int errors;

        function void set_reg(t_cfg_reg idx, logic [15:0] v);
            case (idx)
                REG_MOVE_GAIN:     move_gain = v[7:0];
                REG_SCROLL_GAIN:   scroll_gain = v[7:0];
                REG_MOVE_WINDOW:   move_win = v[3:0];
                REG_SCROLL_WINDOW: scroll_win = v[3:0];
                REG_HOVER_LIMIT:   hover = $signed(v);
                REG_CLICK_PREPARE: prep = $signed(v);
                REG_CLICK_PRESS:   press = $signed(v);
                REG_CLICK_RELEASE: rel_lvl = $signed(v);
                default: ;
            endcase
        endfunction

        function int eff_win(int w);
            if (w < 1) return 1;
            if (w > 8) return 8;
            return w;
        endfunction

        function logic signed [15:0] sat16(longint v);
            if (v > 32767) return 16'sh7FFF;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function longint div_round(longint num, longint den);
            longint mag;
            longint q;
            mag = num < 0 ? -num : num;
            q = (2 * mag + den) / (2 * den);
            return num < 0 ? -q : q;
        endfunction

        function void clear_window();
            foreach (win_dx[i]) begin
                win_dx[i] = 0;
                win_dy[i] = 0;
            end
        endfunction

        function void push_window(int w, longint ndx, longint ndy,
                                  output longint sx, output longint sy);
            sx = 0;
            sy = 0;
            for (int i = 0; i + 1 < w; i++) begin
                win_dx[i] = win_dx[i + 1];
                win_dy[i] = win_dy[i + 1];
                sx += win_dx[i];
                sy += win_dy[i];
            end
            win_dx[w - 1] = ndx;
            win_dy[w - 1] = ndy;
            sx += ndx;
            sy += ndy;
        endfunction

        function void pointer_frame(int x, int y, int z, inout t_result r);
            int cdx;
            int cdy;
            int w;
            longint sx;
            longint sy;
            if (z > hover) begin
                ptr_restart = 1'b1;
                return;
            end
            if (ptr_restart) begin
                ptr_restart = 1'b0;
                clear_window();
                ref_x = x;
                ref_y = y;
            end
            if (z < prep && z != last_depth) begin
                last_depth = z;
                if (z < press && !latched) begin
                    latched = 1'b1;
                    r.click = 1'b1;
                end
            end
            if (z > rel_lvl && latched) latched = 1'b0;
            if (z > prep) begin
                cdx = (x - ref_x) * move_gain;
                cdy = (ref_y - y) * move_gain;
                ref_x = x;
                ref_y = y;
                if (cdx != 0 || cdy != 0) begin
                    w = eff_win(move_win);
                    push_window(w, cdx, cdy, sx, sy);
                    r.move_valid = 1'b1;
                    r.move_dx = sat16(sx / (w * 256));
                    r.move_dy = sat16(sy / (w * 256));
                end
            end
        endfunction

        function void scroll_frame(int x1, int y1, int z1, int x2, int y2, int z2,
                                   inout t_result r);
            int x;
            int y;
            int z;
            int cdx;
            int cdy;
            int w;
            longint sx;
            longint sy;
            z = (z1 + z2) >>> 1;
            if (z > hover) begin
                scr_restart = 1'b1;
                return;
            end
            x = (x1 + x2) >>> 1;
            y = (y1 + y2) >>> 1;
            if (scr_restart) begin
                scr_restart = 1'b0;
                clear_window();
                ref_x = x;
                ref_y = y;
            end
            if (z != last_depth) begin
                last_depth = z;
                if (z < SCROLL_DEPTH_LIMIT) begin
                    cdy = (ref_y - y) * scroll_gain;
                    cdx = (x - ref_x) * scroll_gain;
                    ref_x = x;
                    ref_y = y;
                    if (cdy != 0) begin
                        w = eff_win(scroll_win);
                        push_window(w, cdx, cdy, sx, sy);
                        r.wheel_valid = 1'b1;
                        r.wheel_vert = sat16(div_round(sy, w * 256));
                        r.wheel_horiz = sat16(div_round(sx, w * 256));
                    end
                end
            end
        endfunction

        function void note_frame(logic [IN_W-1:0] d);
            t_result r;
            logic [3:0] cnt;
            r = '0;
            cnt = d[3:0];
            if (cnt == CNT_NONE || cnt == CNT_FIVE) begin
                ptr_restart = 1'b1;
                scr_restart = 1'b1;
            end else if (cnt == CNT_ONE) begin
                scr_restart = 1'b1;
                pointer_frame($signed(d[19:4]), $signed(d[35:20]), $signed(d[51:36]), r);
            end else if (cnt == CNT_TWO) begin
                ptr_restart = 1'b1;
                scroll_frame($signed(d[19:4]), $signed(d[35:20]), $signed(d[51:36]),
                             $signed(d[67:52]), $signed(d[83:68]), $signed(d[99:84]), r);
            end
            pending_events.push_back(r);
            pending_sync.push_back(r.click | r.move_valid | r.wheel_valid);
        endfunction

        task report(string field, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
            errors++;
        endtask

        task check_event(logic [OUT_W-1:0] d);
            t_result e;
            bit s;
            if (pending_events.size() == 0) begin
                $display("unexpected mouse event at %0t: %h", $time, d);
                errors++;
                return;
            end
            e = pending_events.pop_front();
            s = pending_sync.pop_front();
            if (d[0] !== e.click) report("click_pulse", d[0], e.click);
            if (d[1] !== e.move_valid) report("move_valid", d[1], e.move_valid);
            if (d[17:2] !== e.move_dx) report("move_dx", $signed(d[17:2]), e.move_dx);
            if (d[33:18] !== e.move_dy) report("move_dy", $signed(d[33:18]), e.move_dy);
            if (d[34] !== e.wheel_valid) report("wheel_valid", d[34], e.wheel_valid);
            if (d[50:35] !== e.wheel_vert)
                report("wheel_vert", $signed(d[50:35]), e.wheel_vert);
            if (d[66:51] !== e.wheel_horiz)
                report("wheel_horiz", $signed(d[66:51]), e.wheel_horiz);
            if (d[67] !== s) report("sync_pulse", d[67], s);
        endtask
    endclass

    mouse_event_board board = new();

    fingertip_to_mouse_converter DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_event(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("fingertip_to_mouse_converter test failed");
            $finish;
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    function automatic logic [IN_W-1:0] pack_frame(logic [3:0] cnt, logic [15:0] x,
        logic [15:0] y, logic [15:0] z, logic [15:0] x2, logic [15:0] y2, logic [15:0] z2);
        return {4'b0, z2, y2, x2, z, y, x, cnt};
    endfunction

    function automatic int near(int v);
        return v + int'($urandom_range(0, 6)) - 3;
    endfunction

    function automatic logic [IN_W-1:0] next_frame();
        int kind;
        int z;
        int z2;
        kind = $urandom_range(0, 99);
        cur_x += int'($urandom_range(0, 80)) - 40;
        cur_y += int'($urandom_range(0, 80)) - 40;
        if ($urandom_range(0, 19) == 0) begin
            cur_x = $signed(16'($urandom));
            cur_y = $signed(16'($urandom));
        end
        if (kind < 45) begin
            case ($urandom_range(0, 5))
                0: z = near(board.hover);
                1: z = near(board.prep);
                2: z = near(board.press);
                3: z = near(board.rel_lvl);
                4: z = last_z;
                default: z = int'($urandom_range(0, 1600)) - 1200;
            endcase
            last_z = z;
            return pack_frame(CNT_ONE, cur_x, cur_y, z, $urandom, $urandom, $urandom);
        end
        if (kind < 80) begin
            z = int'($urandom_range(0, 500)) - 1000;
            z2 = ($urandom_range(0, 7) == 0) ? z : int'($urandom_range(0, 500)) - 1000;
            if ($urandom_range(0, 9) == 0) z = near(board.hover * 2);
            return pack_frame(CNT_TWO, cur_x, cur_y, z,
                              cur_x + int'($urandom_range(0, 60)) - 30,
                              cur_y + int'($urandom_range(0, 60)) - 30, z2);
        end
        if (kind < 88)
            return pack_frame($urandom_range(0, 1) ? CNT_NONE : CNT_FIVE,
                              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        return pack_frame($urandom_range(0, 15), $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
    endfunction

    task automatic send_frame(logic [IN_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_frame(d);
    endtask

    task automatic drain_events();
        s_axis_tvalid <= 1'b0;
        while (board.pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [15:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.set_reg(idx, v);
    endtask

    task automatic load_settings(int ph);
        logic [15:0] v[8];
        case (ph)
            1: v = '{16'd255, 16'd255, 16'd8, 16'd8, 16'h7FFF, -16'sd600, -16'sd900,
                     -16'sd500};
            2: v = '{16'd16, 16'd32, 16'd0, 16'd15, 16'd320, -16'sd640, -16'sd800,
                     -16'sd640};
            3: v = '{16'd0, 16'd0, 16'd1, 16'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
            4: v = '{16'd200, 16'd100, 16'd6, 16'd2, 16'd100, -16'sd700, -16'sd600,
                     -16'sd900};
            7: v = '{16'd1, 16'd1, 16'd2, 16'd4, 16'd0, -16'sd640, -16'sd800, -16'sd640};
            default: begin
                v[REG_MOVE_GAIN] = $urandom;
                v[REG_SCROLL_GAIN] = $urandom;
                v[REG_MOVE_WINDOW] = $urandom;
                v[REG_SCROLL_WINDOW] = $urandom;
                v[REG_HOVER_LIMIT] = int'($urandom_range(0, 800)) - 400;
                v[REG_CLICK_PREPARE] = int'($urandom_range(0, 600)) - 900;
                v[REG_CLICK_PRESS] = int'($urandom_range(0, 600)) - 1000;
                v[REG_CLICK_RELEASE] = int'($urandom_range(0, 600)) - 900;
            end
        endcase
        for (int i = 0; i < 8; i++) write_reg(t_cfg_reg'(i), v[i]);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        send_idle = 35;
        recv_idle = 63;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(pack_frame(CNT_NONE, 0, 0, 0, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 100, 100, 0, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 164, 90, 0, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 170, 80, 400, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 200, 50, -640, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 200, 50, -900, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 210, 50, -900, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 220, 60, -700, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 300, 70, -600, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 300, 70, -1000, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 16'h7FFF, 16'h8000, 0, 0, 0, 0));
        send_frame(pack_frame(CNT_ONE, 16'h8000, 16'h7FFF, 0, 0, 0, 0));
        send_frame(pack_frame(4'd3, 1, 1, 1, 1, 1, 1));
        send_frame(pack_frame(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF));
        send_frame(pack_frame(CNT_FIVE, 0, 0, 0, 0, 0, 0));
        send_frame(pack_frame(CNT_TWO, 0, 0, -800, 10, 20, -900));
        send_frame(pack_frame(CNT_TWO, 100, -200, -810, 110, -180, -901));
        send_frame(pack_frame(CNT_TWO, 150, -300, -810, 160, -280, -901));
        send_frame(pack_frame(CNT_TWO, 0, 0, 500, 0, 0, 500));
        send_frame(pack_frame(CNT_TWO, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                              16'h8000));
        send_frame(pack_frame(CNT_TWO, 16'h8000, 16'h8000, 16'h8001, 16'h8000, 16'h8000,
                              16'h8000));
        send_frame(pack_frame(4'd10, 0, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 8; ph++) begin
            if (ph >= 6) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (ph >= 3) begin
                send_idle = 63;
                recv_idle = 35;
            end
            if (ph > 0) load_settings(ph);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if ((ph == 1 || ph == 6) && n == 60) hold_req = 1'b1;
                send_frame(next_frame());
            end
            drain_events();
        end

        if (board.errors == 0) begin
            $display("fingertip_to_mouse_converter test passed");
        end else begin
            $display("fingertip_to_mouse_converter test failed");
        end
        $finish;
    end
endmodule
